[sv/dmn_pkg.sv]
// ---------------------------------------------------------------------------
// dmn_pkg
// Types and codes shared by the mutual exclusion node: transaction payloads,
// command and message codes, and the controller/datapath interface.
// ---------------------------------------------------------------------------
package dmn_pkg;

   localparam int NODE_ID_W    = 4;
   localparam int NODE_COUNT_W = 5;
   localparam int STAMP_W      = 32;
   localparam int CSR_DATA_W   = 5;

   // local commands
   localparam logic [1:0] CMD_REQUEST = 2'd0;
   localparam logic [1:0] CMD_RELEASE = 2'd1;
   localparam logic [1:0] CMD_END     = 2'd2;
   localparam logic [1:0] CMD_MESSAGE = 2'd3;

   // message kinds
   localparam logic [1:0] MSG_REQUEST = 2'd0;
   localparam logic [1:0] MSG_REPLY   = 2'd1;
   localparam logic [1:0] MSG_END     = 2'd2;

   // configuration register indexes
   localparam logic CSR_NODE_ID    = 1'b0;
   localparam logic CSR_NODE_COUNT = 1'b1;

   // what the output register is loaded with
   localparam logic [1:0] SEL_EMPTY = 2'd0;
   localparam logic [1:0] SEL_BCAST = 2'd1;
   localparam logic [1:0] SEL_DEFER = 2'd2;
   localparam logic [1:0] SEL_REPLY = 2'd3;

   typedef struct packed {
      logic [1:0]           command;
      logic [1:0]           msg_kind;
      logic [NODE_ID_W-1:0] msg_source;
      logic [STAMP_W-1:0]   msg_clock;
   } req_type;

   typedef struct packed {
      logic                 send_valid;
      logic [NODE_ID_W-1:0] send_dest;
      logic [1:0]           send_kind;
      logic [STAMP_W-1:0]   send_stamp;
      logic                 granted;
      logic                 all_ended;
      logic                 last;
   } rsp_type;

   typedef struct packed {
      logic       accept;  // apply the accepted transaction to node state
      logic       rd;      // read deferred queue at the sequence index
      logic       emit;    // load the output register
      logic [1:0] sel;
   } ctrl_type;

   typedef struct packed {
      logic slot_free;   // output register can take a result this cycle
      logic reply_now;   // arriving request is answered at once
      logic defer_any;   // deferred queue holds entries
      logic bc_none;     // broadcast has no destination
      logic bc_last;     // current broadcast destination is the final one
      logic rel_last;    // current deferred entry is the final one
   } stat_type;

endpackage

[sv/distributed_mutex_node.sv]
// ---------------------------------------------------------------------------
// distributed_mutex_node
// One node of a Ricart-Agrawala mutual exclusion scheme with a saturating
// Lamport clock: local commands and arriving messages in, outgoing messages
// with granted / all-ended status out.
// ---------------------------------------------------------------------------
// After a transaction is taken, the controller loads its first result into the output
//   register when it is free (a release with deferred requesters reads the queue first).
// Throughput: broadcasts give one result per cycle while the output is not stalled
//   (up to MAX_NODES-1); each release reply takes a registered queue read, then output.
// A new transaction is taken once the last result has entered the output reg.
// Reset clears node state, node_id to 0 and node_count to 2; queue needs no clear.
module distributed_mutex_node #(
   parameter int MAX_NODES  = 16,
   parameter int CLOCK_BITS = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic                           csr_index,
   input  logic [dmn_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  dmn_pkg::req_type               req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output dmn_pkg::rsp_type               rsp_data
);

   dmn_pkg::ctrl_type ctrl;
   dmn_pkg::stat_type stat;

   dmn_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_command (req_data.command),
      .stat        (stat),
      .req_ready   (req_ready),
      .ctrl        (ctrl)
   );

   dmn_dpath #(
      .MAX_NODES  (MAX_NODES),
      .CLOCK_BITS (CLOCK_BITS)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_data  (req_data),
      .ctrl      (ctrl),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

[sv/dmn_ctrl.sv]
// ---------------------------------------------------------------------------
// dmn_ctrl
// Sequencer of the node: takes one transaction at a time and walks the
// outgoing messages it causes through the output register.
// ---------------------------------------------------------------------------
module dmn_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic [1:0]        req_command,
   input  dmn_pkg::stat_type stat,
   output logic              req_ready,
   output dmn_pkg::ctrl_type ctrl
);

   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_BCAST   = 3'd1;
   localparam logic [2:0] S_REL_RD  = 3'd2;
   localparam logic [2:0] S_REL_OUT = 3'd3;
   localparam logic [2:0] S_REPLY   = 3'd4;
   localparam logic [2:0] S_EMPTY   = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in    = state_ff;
      ctrl.accept = 1'b0;
      ctrl.rd     = 1'b0;
      ctrl.emit   = 1'b0;
      ctrl.sel    = dmn_pkg::SEL_EMPTY;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               ctrl.accept = 1'b1;
               case (req_command)
                  dmn_pkg::CMD_REQUEST: state_in = S_BCAST;
                  dmn_pkg::CMD_END:     state_in = S_BCAST;
                  dmn_pkg::CMD_RELEASE: state_in = stat.defer_any ? S_REL_RD : S_EMPTY;
                  default:              state_in = stat.reply_now ? S_REPLY : S_EMPTY;
               endcase
            end
         end
         S_BCAST: begin
            if (stat.slot_free) begin
               ctrl.emit = 1'b1;
               if (stat.bc_none) begin
                  ctrl.sel = dmn_pkg::SEL_EMPTY;
                  state_in = S_IDLE;
               end else begin
                  ctrl.sel = dmn_pkg::SEL_BCAST;
                  if (stat.bc_last) begin
                     state_in = S_IDLE;
                  end
               end
            end
         end
         S_REL_RD: begin
            ctrl.rd  = 1'b1;
            state_in = S_REL_OUT;
         end
         S_REL_OUT: begin
            if (stat.slot_free) begin
               ctrl.emit = 1'b1;
               ctrl.sel  = dmn_pkg::SEL_DEFER;
               state_in  = stat.rel_last ? S_IDLE : S_REL_RD;
            end
         end
         S_REPLY: begin
            if (stat.slot_free) begin
               ctrl.emit = 1'b1;
               ctrl.sel  = dmn_pkg::SEL_REPLY;
               state_in  = S_IDLE;
            end
         end
         S_EMPTY: begin
            if (stat.slot_free) begin
               ctrl.emit = 1'b1;
               ctrl.sel  = dmn_pkg::SEL_EMPTY;
               state_in  = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[sv/dmn_dpath.sv]
// ---------------------------------------------------------------------------
// dmn_dpath
// Node state (Lamport clock, request stamp, counters, deferred queue),
// configuration registers, message sequencing index and output register.
// ---------------------------------------------------------------------------
module dmn_dpath #(
   parameter int MAX_NODES  = 16,
   parameter int CLOCK_BITS = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic                              csr_index,
   input  logic [dmn_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  dmn_pkg::req_type                  req_data,
   input  dmn_pkg::ctrl_type                 ctrl,
   output dmn_pkg::stat_type                 stat,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output dmn_pkg::rsp_type                  rsp_data
);

   localparam int CNT_W = $clog2(MAX_NODES);
   localparam int IDX_W = $clog2(MAX_NODES + 2);
   localparam int CMP_W = IDX_W + dmn_pkg::NODE_COUNT_W;
   localparam int DEPTH = MAX_NODES - 1;
   localparam int WIDE  = (CLOCK_BITS > dmn_pkg::STAMP_W) ? CLOCK_BITS : dmn_pkg::STAMP_W;
   localparam logic [CLOCK_BITS-1:0] CLK_MAX = {CLOCK_BITS{1'b1}};
   localparam logic [CNT_W-1:0]      CNT_MAX = CNT_W'(MAX_NODES - 1);
   localparam logic [CNT_W-1:0]      SEQ_CAP = CNT_W'(MAX_NODES - 2);
   localparam logic [IDX_W-1:0]      NODES   = IDX_W'(MAX_NODES);

   // configuration
   logic [dmn_pkg::NODE_ID_W-1:0]    node_id_ff;
   logic [dmn_pkg::NODE_COUNT_W-1:0] node_count_ff;

   // node state
   logic [CLOCK_BITS-1:0] clock_ff, clock_in;
   logic [CLOCK_BITS-1:0] rstamp_ff, rstamp_in;
   logic                  wanting_ff, wanting_in;
   logic [CNT_W-1:0]      reply_cnt_ff, reply_cnt_in;
   logic [CNT_W-1:0]      end_cnt_ff, end_cnt_in;
   logic [CNT_W-1:0]      dcount_ff, dcount_in;
   logic [dmn_pkg::NODE_ID_W-1:0] defer_mem [DEPTH];

   // sequencing
   logic [IDX_W-1:0]              seq_idx_ff, seq_idx_in;
   logic [CNT_W-1:0]              seq_num_ff, seq_num_in;
   logic [CNT_W-1:0]              rel_total_ff;
   logic [1:0]                    kind_ff;
   logic [dmn_pkg::NODE_ID_W-1:0] src_ff;
   logic [dmn_pkg::NODE_ID_W-1:0] rd_data_ff;

   // output register
   logic             rsp_valid_ff;
   dmn_pkg::rsp_type rsp_ff, rsp_in;

   logic [IDX_W-1:0]      n_eff;
   logic [IDX_W-1:0]      need;
   logic [IDX_W-1:0]      bc_next;
   logic [WIDE-1:0]       mclk_wide;
   logic [CLOCK_BITS-1:0] msat;
   logic [CLOCK_BITS-1:0] mmax;
   logic                  sender_first;
   logic                  is_msg;
   logic                  enqueue;
   logic                  granted;
   logic                  ended;
   logic [WIDE-1:0]       stamp_wide;

   function automatic logic [IDX_W-1:0] skip_self(input logic [IDX_W-1:0] x,
                                                  input logic [dmn_pkg::NODE_ID_W-1:0] id);
      logic [IDX_W-1:0] r;
      r = (CMP_W'(x) == CMP_W'(id)) ? x + IDX_W'(1) : x;
      return r;
   endfunction

   function automatic logic [CLOCK_BITS-1:0] clk_next(input logic [CLOCK_BITS-1:0] c);
      logic [CLOCK_BITS-1:0] r;
      r = (c == CLK_MAX) ? c : c + CLOCK_BITS'(1);
      return r;
   endfunction

   assign n_eff = (CMP_W'(node_count_ff) > CMP_W'(NODES)) ? NODES : IDX_W'(node_count_ff);
   assign need  = (n_eff != '0) ? n_eff - IDX_W'(1) : '0;
   assign granted = wanting_ff && (IDX_W'(reply_cnt_ff) >= need);
   assign ended   = IDX_W'(end_cnt_ff) >= need;

   // incoming stamp clipped to the clock range
   assign mclk_wide = WIDE'(req_data.msg_clock);
   assign msat = (mclk_wide > WIDE'(CLK_MAX)) ? CLK_MAX : CLOCK_BITS'(mclk_wide);
   assign mmax = (clock_ff > msat) ? clock_ff : msat;

   assign is_msg = (req_data.command == dmn_pkg::CMD_MESSAGE);
   assign sender_first = !wanting_ff || (rstamp_ff > msat) ||
                         ((rstamp_ff == msat) && (node_id_ff > req_data.msg_source));
   assign enqueue = ctrl.accept && is_msg && (req_data.msg_kind == dmn_pkg::MSG_REQUEST) &&
                    !sender_first && (dcount_ff < CNT_MAX);

   assign bc_next = skip_self(seq_idx_ff + IDX_W'(1), node_id_ff);

   assign stat.slot_free = !rsp_valid_ff || rsp_ready;
   assign stat.reply_now = is_msg && (req_data.msg_kind == dmn_pkg::MSG_REQUEST) && sender_first;
   assign stat.defer_any = (dcount_ff != '0);
   assign stat.bc_none   = (seq_idx_ff >= n_eff);
   assign stat.bc_last   = (seq_num_ff == SEQ_CAP) || (bc_next >= n_eff);
   assign stat.rel_last  = (seq_idx_ff + IDX_W'(1)) == IDX_W'(rel_total_ff);

   // node state update on an accepted transaction
   always_comb begin
      clock_in     = clock_ff;
      rstamp_in    = rstamp_ff;
      wanting_in   = wanting_ff;
      reply_cnt_in = reply_cnt_ff;
      end_cnt_in   = end_cnt_ff;
      dcount_in    = dcount_ff;
      if (ctrl.accept) begin
         case (req_data.command)
            dmn_pkg::CMD_REQUEST: begin
               clock_in     = clk_next(clock_ff);
               rstamp_in    = clk_next(clock_ff);
               reply_cnt_in = '0;
               wanting_in   = 1'b1;
            end
            dmn_pkg::CMD_RELEASE: begin
               clock_in   = clk_next(clock_ff);
               dcount_in  = '0;
               wanting_in = 1'b0;
            end
            dmn_pkg::CMD_END: begin
               clock_in     = clk_next(clock_ff);
               rstamp_in    = clk_next(clock_ff);
               reply_cnt_in = '0;
               wanting_in   = 1'b0;
            end
            default: begin
               clock_in = clk_next(mmax);
               case (req_data.msg_kind)
                  dmn_pkg::MSG_REQUEST: begin
                     if (enqueue) begin
                        dcount_in = dcount_ff + CNT_W'(1);
                     end
                  end
                  dmn_pkg::MSG_REPLY: begin
                     if (reply_cnt_ff < CNT_MAX) begin
                        reply_cnt_in = reply_cnt_ff + CNT_W'(1);
                     end
                  end
                  dmn_pkg::MSG_END: begin
                     if (end_cnt_ff < CNT_MAX) begin
                        end_cnt_in = end_cnt_ff + CNT_W'(1);
                     end
                  end
                  default: begin
                  end
               endcase
            end
         endcase
      end
   end

   // sequencing index: broadcast rank or deferred queue slot
   always_comb begin
      seq_idx_in = seq_idx_ff;
      seq_num_in = seq_num_ff;
      if (ctrl.accept) begin
         seq_idx_in = (req_data.command == dmn_pkg::CMD_RELEASE) ?
                      '0 : skip_self('0, node_id_ff);
         seq_num_in = '0;
      end else if (ctrl.emit && (ctrl.sel == dmn_pkg::SEL_BCAST)) begin
         seq_idx_in = bc_next;
         seq_num_in = seq_num_ff + CNT_W'(1);
      end else if (ctrl.emit && (ctrl.sel == dmn_pkg::SEL_DEFER)) begin
         seq_idx_in = seq_idx_ff + IDX_W'(1);
      end
   end

   assign stamp_wide = WIDE'(clock_ff);

   always_comb begin
      rsp_in.send_valid = 1'b1;
      rsp_in.send_kind  = dmn_pkg::MSG_REPLY;
      rsp_in.send_dest  = src_ff;
      rsp_in.send_stamp = stamp_wide[dmn_pkg::STAMP_W-1:0];
      rsp_in.granted    = granted;
      rsp_in.all_ended  = ended;
      rsp_in.last       = 1'b1;
      case (ctrl.sel)
         dmn_pkg::SEL_BCAST: begin
            rsp_in.send_dest = dmn_pkg::NODE_ID_W'(seq_idx_ff);
            rsp_in.send_kind = kind_ff;
            rsp_in.last      = stat.bc_last;
         end
         dmn_pkg::SEL_DEFER: begin
            rsp_in.send_dest = rd_data_ff;
            rsp_in.last      = stat.rel_last;
         end
         dmn_pkg::SEL_REPLY: begin
         end
         default: begin
            rsp_in.send_valid = 1'b0;
            rsp_in.send_dest  = '0;
            rsp_in.send_kind  = dmn_pkg::MSG_REQUEST;
            rsp_in.send_stamp = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         node_id_ff    <= '0;
         node_count_ff <= dmn_pkg::NODE_COUNT_W'(2);
         clock_ff      <= '0;
         rstamp_ff     <= '0;
         wanting_ff    <= 1'b0;
         reply_cnt_ff  <= '0;
         end_cnt_ff    <= '0;
         dcount_ff     <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_we && (csr_index == dmn_pkg::CSR_NODE_ID)) begin
            node_id_ff <= dmn_pkg::NODE_ID_W'(csr_wdata);
         end
         if (csr_we && (csr_index == dmn_pkg::CSR_NODE_COUNT)) begin
            node_count_ff <= csr_wdata;
         end
         clock_ff     <= clock_in;
         rstamp_ff    <= rstamp_in;
         wanting_ff   <= wanting_in;
         reply_cnt_ff <= reply_cnt_in;
         end_cnt_ff   <= end_cnt_in;
         dcount_ff    <= dcount_in;
         if (ctrl.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      seq_idx_ff <= seq_idx_in;
      seq_num_ff <= seq_num_in;
      if (ctrl.accept) begin
         kind_ff      <= (req_data.command == dmn_pkg::CMD_END) ?
                         dmn_pkg::MSG_END : dmn_pkg::MSG_REQUEST;
         src_ff       <= req_data.msg_source;
         rel_total_ff <= dcount_ff;
      end
      if (ctrl.emit) begin
         rsp_ff <= rsp_in;
      end
   end

   // deferred requester queue
   always_ff @(posedge clock) begin
      if (enqueue) begin
         defer_mem[dcount_ff] <= req_data.msg_source;
      end
      if (ctrl.rd) begin
         rd_data_ff <= defer_mem[seq_idx_ff[CNT_W-1:0]];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_emit_slot: assert property (@(posedge clock) disable iff (reset)
      ctrl.emit |-> (!rsp_valid_ff || rsp_ready))
      else $error("result loaded over a stalled result");

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      (dcount_ff <= CNT_MAX) && (reply_cnt_ff <= CNT_MAX) && (end_cnt_ff <= CNT_MAX))
      else $error("counter beyond node limit");

   a_clock_adv: assert property (@(posedge clock) disable iff (reset)
      ctrl.accept |=> (clock_ff > $past(clock_ff)) || (clock_ff == CLK_MAX))
      else $error("Lamport clock did not advance");

   a_release_drop: assert property (@(posedge clock) disable iff (reset)
      ctrl.accept && (req_data.command == dmn_pkg::CMD_RELEASE)
      |=> !wanting_ff && (dcount_ff == '0))
      else $error("release left request state behind");

endmodule

[tb/dmn_tb_pkg.sv]
// ---------------------------------------------------------------------------
// dmn_tb_pkg
// Scoreboard for the mutual exclusion node: tracks the node's clock, request
// stamp, reply/end counts and deferred requesters, expands every accepted
// transaction into the outgoing messages it must cause, and checks results.
// ---------------------------------------------------------------------------
package dmn_tb_pkg;
   import dmn_pkg::*;

   localparam int                 PEER_LIMIT  = 16;   // MAX_NODES of the instance
   localparam logic [STAMP_W-1:0] STAMP_MAX   = '1;
   localparam logic [1:0]         MSG_UNKNOWN = 2'd3; // kind with no meaning

   class mutex_tracker;
      logic [NODE_ID_W-1:0]    node_id;
      logic [NODE_COUNT_W-1:0] node_count;
      logic [STAMP_W-1:0]      lamport;
      logic [STAMP_W-1:0]      own_stamp;
      bit                      wanting;
      int                      replies;
      int                      ends;
      logic [NODE_ID_W-1:0]    deferred[$];
      rsp_type                 burst[$];
      rsp_type                 pending_msgs[$];
      int                      mismatches;

      function new();
         node_id    = '0;
         node_count = 5'd2;
         lamport    = '0;
         own_stamp  = '0;
         wanting    = 1'b0;
         replies    = 0;
         ends       = 0;
         mismatches = 0;
      endfunction

      function int peers();
         return (node_count > PEER_LIMIT) ? PEER_LIMIT : int'(node_count);
      endfunction

      function void write_reg(logic idx, logic [CSR_DATA_W-1:0] val);
         if (idx == CSR_NODE_ID) begin
            node_id = val[NODE_ID_W-1:0];
         end else begin
            node_count = val[NODE_COUNT_W-1:0];
         end
      endfunction

      function logic [STAMP_W-1:0] tick(logic [STAMP_W-1:0] c);
         return (c == STAMP_MAX) ? c : c + 1'b1;
      endfunction

      function rsp_type outgoing(int dest, logic [1:0] kind);
         rsp_type r;
         r            = '0;
         r.send_valid = 1'b1;
         r.send_dest  = dest[NODE_ID_W-1:0];
         r.send_kind  = kind;
         r.send_stamp = lamport;
         return r;
      endfunction

      // broadcast skips this node; capped at PEER_LIMIT-1 destinations
      function void fan_out(logic [1:0] kind);
         for (int i = 0; i < peers(); i++) begin
            if (i == node_id) continue;
            if (burst.size() >= PEER_LIMIT - 1) break;
            burst.push_back(outgoing(i, kind));
         end
      endfunction

      function void take_command(req_type it);
         rsp_type            r;
         logic [STAMP_W-1:0] top;
         bit                 sender_first;
         int                 need;
         burst.delete();
         case (it.command)
            CMD_REQUEST: begin
               lamport   = tick(lamport);
               own_stamp = lamport;
               replies   = 0;
               wanting   = 1'b1;
               fan_out(MSG_REQUEST);
            end
            CMD_RELEASE: begin
               lamport = tick(lamport);
               foreach (deferred[i]) burst.push_back(outgoing(deferred[i], MSG_REPLY));
               deferred.delete();
               wanting = 1'b0;
            end
            CMD_END: begin
               lamport   = tick(lamport);
               own_stamp = lamport;
               replies   = 0;
               wanting   = 1'b0;
               fan_out(MSG_END);
            end
            CMD_MESSAGE: begin
               top     = (lamport > it.msg_clock) ? lamport : it.msg_clock;
               lamport = tick(top);
               case (it.msg_kind)
                  MSG_REQUEST: begin
                     sender_first = !wanting || own_stamp > it.msg_clock ||
                                    (own_stamp == it.msg_clock && node_id > it.msg_source);
                     if (sender_first) begin
                        burst.push_back(outgoing(it.msg_source, MSG_REPLY));
                     end else if (deferred.size() < PEER_LIMIT - 1) begin
                        deferred.push_back(it.msg_source);
                     end
                  end
                  MSG_REPLY: begin
                     if (replies < PEER_LIMIT - 1) replies++;
                  end
                  MSG_END: begin
                     if (ends < PEER_LIMIT - 1) ends++;
                  end
                  default: ;
               endcase
            end
         endcase
         if (burst.size() == 0) burst.push_back('0);
         need = peers() - 1;
         foreach (burst[i]) begin
            r           = burst[i];
            r.granted   = wanting && replies >= need;
            r.all_ended = ends >= need;
            r.last      = (i == burst.size() - 1);
            pending_msgs.push_back(r);
         end
      endfunction

      function void compare(string field, logic [STAMP_W-1:0] want, logic [STAMP_W-1:0] got);
         if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
            mismatches++;
         end
      endfunction

      function void check_message(rsp_type got);
         rsp_type want;
         if (pending_msgs.size() == 0) begin
            $error("unexpected result transaction 0x%0h", got);
            mismatches++;
            return;
         end
         want = pending_msgs.pop_front();
         compare("send_valid", want.send_valid, got.send_valid);
         compare("send_dest",  want.send_dest,  got.send_dest);
         compare("send_kind",  want.send_kind,  got.send_kind);
         compare("send_stamp", want.send_stamp, got.send_stamp);
         compare("granted",    want.granted,    got.granted);
         compare("all_ended",  want.all_ended,  got.all_ended);
         compare("last",       want.last,       got.last);
      endfunction
   endclass

endpackage

[tb/tb_top.sv]
// ---------------------------------------------------------------------------
// tb_top
// Drives local commands and arriving messages into the mutual exclusion node
// under random flow control: directed corner cases, request/reply/release
// rounds and queue floods across several node setups, then a saturated clock.
// ---------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import dmn_pkg::*;
   import dmn_tb_pkg::*;

   logic                  clock;
   logic                  reset     = 1'b1;
   logic                  csr_we    = 1'b0;
   logic                  csr_index = CSR_NODE_ID;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               req_data  = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp_data;

   mutex_tracker tracker = new();
   bit           idle_on = 1'b1;
   int           sent    = 0;

   distributed_mutex_node u_dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #15ms;
      $display("FAILED: results differ");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) tracker.check_message(rsp_data);
   end

   // result side back-pressure
   initial begin
      @(posedge clock);
      forever begin
         if (idle_on && $urandom_range(0, 7) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
      end
   end

   function automatic req_type item(logic [1:0] cmd, logic [1:0] kind, int src,
                                    logic [STAMP_W-1:0] stamp);
      req_type it;
      it.command    = cmd;
      it.msg_kind   = kind;
      it.msg_source = src[NODE_ID_W-1:0];
      it.msg_clock  = stamp;
      return it;
   endfunction

   // local commands carry random junk in the message fields
   function automatic req_type local_cmd(logic [1:0] cmd);
      return item(cmd, 2'($urandom_range(0, 3)), $urandom_range(0, 15), $urandom);
   endfunction

   function automatic logic [STAMP_W-1:0] near(logic [STAMP_W-1:0] base, int spread);
      longint v;
      v = longint'(base) + longint'($urandom_range(0, 2 * spread)) - spread;
      if (v < 0) v = 0;
      if (v > longint'(STAMP_MAX)) v = longint'(STAMP_MAX);
      return STAMP_W'(v);
   endfunction

   task automatic drive(req_type it);
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= it;
      do @(posedge clock); while (!req_ready);
      tracker.take_command(it);
      sent++;
   endtask

   task automatic drain();
      if (req_valid) req_valid <= 1'b0;
      while (tracker.pending_msgs.size() != 0) @(posedge clock);
   endtask

   task automatic configure(int id, int count);
      drain();
      csr_we    <= 1'b1;
      csr_index <= CSR_NODE_ID;
      csr_wdata <= CSR_DATA_W'(id);
      tracker.write_reg(CSR_NODE_ID, CSR_DATA_W'(id));
      @(posedge clock);
      csr_index <= CSR_NODE_COUNT;
      csr_wdata <= CSR_DATA_W'(count);
      tracker.write_reg(CSR_NODE_COUNT, CSR_DATA_W'(count));
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic noise();
      drive(item(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)), $urandom_range(0, 15),
                 near(tracker.lamport, 6)));
   endtask

   // request, competing requests and replies from the peers, then leave
   task automatic contend_round();
      int                 order[$];
      int                 j;
      int                 t;
      int                 src;
      logic [STAMP_W-1:0] stamp;
      for (int i = 0; i < tracker.peers(); i++) begin
         if (i != tracker.node_id) order.push_back(i);
      end
      for (int i = order.size() - 1; i > 0; i--) begin
         j        = $urandom_range(0, i);
         t        = order[i];
         order[i] = order[j];
         order[j] = t;
      end
      drive(local_cmd(CMD_REQUEST));
      stamp = tracker.own_stamp;
      foreach (order[i]) begin
         if ($urandom_range(0, 2) == 0) begin
            src = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15)
                                              : order[$urandom_range(0, order.size() - 1)];
            drive(item(CMD_MESSAGE, MSG_REQUEST, src, near(stamp, 2)));
         end
         if ($urandom_range(0, 9) == 0)
            drive(item(CMD_MESSAGE, MSG_END, order[i], near(tracker.lamport, 3)));
         if ($urandom_range(0, 7) != 0)
            drive(item(CMD_MESSAGE, MSG_REPLY, order[i], near(tracker.lamport, 3)));
      end
      if ($urandom_range(0, 9) == 0) noise();
      drive(local_cmd(($urandom_range(0, 6) == 0) ? CMD_END : CMD_RELEASE));
   endtask

   // younger requests pile up, at times past the queue depth, then one release answers the queued ones
   task automatic flood_round();
      logic [STAMP_W-1:0] stamp;
      drive(local_cmd(CMD_REQUEST));
      stamp = tracker.own_stamp;
      repeat ($urandom_range(10, 17))
         drive(item(CMD_MESSAGE, MSG_REQUEST, $urandom_range(0, 15),
                    stamp + $urandom_range(1, 3)));
      drive(local_cmd(CMD_RELEASE));
   endtask

   initial begin
      int                 ids[6];
      int                 counts[6];
      int                 pick;
      logic [STAMP_W-1:0] stamp;

      ids    = '{0, 15, 12, 7, 5, 0};
      counts = '{2, 16, 4, 31, 9, 0};
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      configure(3, 5);
      drive(item(CMD_MESSAGE, MSG_REPLY, 1, 0));     // reply counted while idle
      drive(item(CMD_MESSAGE, MSG_REQUEST, 1, 0));   // not requesting: answered at once
      drive(local_cmd(CMD_REQUEST));
      stamp = tracker.own_stamp;
      drive(item(CMD_MESSAGE, MSG_REQUEST, 2, stamp));       // tie, lower rank wins
      drive(item(CMD_MESSAGE, MSG_REQUEST, 4, stamp));       // tie, deferred
      drive(item(CMD_MESSAGE, MSG_REQUEST, 0, stamp - 1));   // older request wins
      drive(item(CMD_MESSAGE, MSG_REQUEST, 15, stamp + 5));  // deferred
      drive(item(CMD_MESSAGE, MSG_UNKNOWN, 15, 0));          // clock only
      drive(item(CMD_MESSAGE, MSG_REPLY, 0, tracker.lamport));
      drive(item(CMD_MESSAGE, MSG_REPLY, 1, tracker.lamport));
      drive(item(CMD_MESSAGE, MSG_REPLY, 2, tracker.lamport));
      drive(item(CMD_MESSAGE, MSG_REPLY, 4, tracker.lamport));
      drive(item(CMD_MESSAGE, MSG_REPLY, 1, tracker.lamport));
      drive(local_cmd(CMD_RELEASE));
      drive(local_cmd(CMD_RELEASE));                 // nothing deferred
      drive(item(CMD_MESSAGE, MSG_END, 0, 0));
      drive(item(CMD_MESSAGE, MSG_END, 1, 0));
      drive(item(CMD_MESSAGE, MSG_END, 2, 0));
      drive(item(CMD_MESSAGE, MSG_END, 4, 0));
      drive(local_cmd(CMD_END));
      drive(item(CMD_MESSAGE, MSG_REQUEST, 7, 0));

      for (int phase = 0; phase < 6; phase++) begin
         if (phase == 5) begin
            configure($urandom_range(0, 15), $urandom_range(2, 16));
         end else begin
            configure(ids[phase], counts[phase]);
         end
         while (sent < 21 + 50 * (phase + 1)) begin
            idle_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 19) == 0) drain();
            pick = $urandom_range(0, 9);
            if (pick <= 5) begin
               contend_round();
            end else if (pick == 6) begin
               flood_round();
            end else begin
               repeat ($urandom_range(1, 4)) noise();
            end
         end
      end

      // full-width stamps, then the clock pinned at its maximum
      idle_on = 1'b0;
      configure(6, 16);
      repeat (8)
         drive(item(CMD_MESSAGE, 2'($urandom_range(0, 3)), $urandom_range(0, 15), $urandom));
      drive(item(CMD_MESSAGE, MSG_REQUEST, 9, STAMP_MAX));
      drive(local_cmd(CMD_REQUEST));
      drive(item(CMD_MESSAGE, MSG_REQUEST, 9, STAMP_MAX));   // tie, deferred
      drive(item(CMD_MESSAGE, MSG_REQUEST, 2, STAMP_MAX));   // tie, answered
      drive(item(CMD_MESSAGE, MSG_REPLY, 0, STAMP_MAX));
      drive(item(CMD_MESSAGE, MSG_END, 1, STAMP_MAX));
      drive(local_cmd(CMD_RELEASE));
      drive(local_cmd(CMD_END));

      drain();
      repeat (20) @(posedge clock);
      if (tracker.mismatches == 0 && tracker.pending_msgs.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

[files.f]
sv/dmn_pkg.sv
sv/dmn_ctrl.sv
sv/dmn_dpath.sv
sv/distributed_mutex_node.sv
tb/dmn_tb_pkg.sv
tb/tb_top.sv
